/* design/grn_pkg.sv */
// Shared types, register indexes and default sizes for the grid rotation block.
package grn_pkg;

  // Default sizes of the source store and the fraction width of the trig inputs.
  localparam int unsigned MAX_SRC_WIDTH_DEF  = 1024;
  localparam int unsigned MAX_SRC_HEIGHT_DEF = 1024;
  localparam int unsigned TRIG_FRAC_BITS_DEF = 14;

  // Configuration port.
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 16;

  localparam logic [CFG_IDX_W-1:0] CFG_SRC_WIDTH  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SRC_HEIGHT = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_DST_WIDTH  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_DST_HEIGHT = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_COS_Q      = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_SIN_Q      = 3'd5;

  // Item opcodes.
  localparam logic OP_LOAD  = 1'b0;
  localparam logic OP_QUERY = 1'b1;

  // Cell value returned for a position outside the source grid.
  localparam logic signed [7:0] CELL_OUTSIDE = -8'sd1;

  typedef struct packed {
    logic [10:0]        src_width;
    logic [10:0]        src_height;
    logic [11:0]        dst_width;
    logic [11:0]        dst_height;
    logic signed [15:0] cos_q;
    logic signed [15:0] sin_q;
  } cfg_t;

  typedef struct packed {
    logic              op;
    logic [10:0]       col;
    logic [10:0]       row;
    logic signed [7:0] cell_in;
  } in_item_t;

  typedef struct packed {
    logic signed [7:0] cell_out;
    logic              outside;
  } out_item_t;

endpackage

/* design/grid_rotate_nearest_top.sv */
// Top level: nearest-cell rotation of an occupancy grid about its center.
//
// Usage
//   Input channel (in_valid_i / in_stall_o / in_data_i): one transfer per item.
//   A load (op = OP_LOAD) writes cell_in into the source store at (col, row);
//   loads outside the store are dropped; a load gives no result. A query
//   (op = OP_QUERY) maps destination cell (col, row) back into the
//   source grid and yields one transfer on the output channel
//   (out_valid_o / out_stall_i / out_data_o): the stored cell, or -1 with the
//   outside flag set when the rounded position lies outside the grid.
//   A query's result is registered through the coordinate registers, the
//   three mapping stages, the store read register and the output register.
//   Loads are taken one per cycle while idle; the input stalls from a query's
//   transfer until its result is handed off. Items are handled one at a time.
//   A finished result sits in the output register; the next item is taken
//   while it waits. A query that finishes while the receiver stalls holds in
//   its last step until the output register frees up.
//   Reset returns the configuration to its defaults and empties the output
//   register. The store is not cleared: read only cells that were loaded.
//   User rule, not enforced: configuration writes (cfg_we_i) only while idle.
module grid_rotate_nearest_top
  import grn_pkg::*;
#(
  parameter int unsigned MAX_SRC_WIDTH  = MAX_SRC_WIDTH_DEF,
  parameter int unsigned MAX_SRC_HEIGHT = MAX_SRC_HEIGHT_DEF,
  parameter int unsigned TRIG_FRAC_BITS = TRIG_FRAC_BITS_DEF
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  // configuration write port
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [CFG_DATA_W-1:0] cfg_wdata_i,
  // input items
  input  logic                  in_valid_i,
  output logic                  in_stall_o,
  input  in_item_t              in_data_i,
  // results
  output logic                  out_valid_o,
  input  logic                  out_stall_i,
  output out_item_t             out_data_o
);

  localparam int unsigned Depth = MAX_SRC_WIDTH * MAX_SRC_HEIGHT;
  localparam int unsigned AddrW = $clog2(Depth);

  // ---------------------------------------------------------------------------
  // Configuration registers
  // ---------------------------------------------------------------------------
  cfg_t cfg_q, cfg_d;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      case (cfg_index_i)
        CFG_SRC_WIDTH:  cfg_d.src_width  = cfg_wdata_i[10:0];
        CFG_SRC_HEIGHT: cfg_d.src_height = cfg_wdata_i[10:0];
        CFG_DST_WIDTH:  cfg_d.dst_width  = cfg_wdata_i[11:0];
        CFG_DST_HEIGHT: cfg_d.dst_height = cfg_wdata_i[11:0];
        CFG_COS_Q:      cfg_d.cos_q      = $signed(cfg_wdata_i);
        CFG_SIN_Q:      cfg_d.sin_q      = $signed(cfg_wdata_i);
        default:        ;  // unused indexes are ignored
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.src_width  <= 11'd1024;
      cfg_q.src_height <= 11'd1024;
      cfg_q.dst_width  <= 12'd1024;
      cfg_q.dst_height <= 12'd1024;
      cfg_q.cos_q      <= 16'sd16384;
      cfg_q.sin_q      <= 16'sd0;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  // ---------------------------------------------------------------------------
  // Sequencer: IDLE takes items; a query walks the mapping stages, the store
  // read and the hand-off into the output register.
  // ---------------------------------------------------------------------------
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL,
    ST_SUM,
    ST_ADR,
    ST_RD,
    ST_DONE
  } state_e;

  state_e    state_q;
  logic      out_valid_q;
  out_item_t out_data_q;

  logic in_xfer, out_xfer, out_free;

  assign in_stall_o = (state_q != ST_IDLE);
  assign in_xfer    = in_valid_i && !in_stall_o;
  assign out_xfer   = out_valid_q && !out_stall_i;
  assign out_free   = !out_valid_q || !out_stall_i;

  // query coordinates, held for the mapping stages
  logic [10:0] col_q, row_q;

  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      col_q <= in_data_i.col;
      row_q <= in_data_i.row;
    end
  end

  // mapping unit and store read data
  logic             map_outside;
  logic [AddrW-1:0] map_addr;
  logic [7:0]       rd_q;

  grn_map #(
    .MAX_SRC_WIDTH  (MAX_SRC_WIDTH),
    .MAX_SRC_HEIGHT (MAX_SRC_HEIGHT),
    .TRIG_FRAC_BITS (TRIG_FRAC_BITS)
  ) u_map (
    .clk_i     (clk_i),
    .cfg_i     (cfg_q),
    .col_i     (col_q),
    .row_i     (row_q),
    .outside_o (map_outside),
    .addr_o    (map_addr)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
      out_data_q  <= '0;
    end else begin
      // in DONE the hand-off below decides valid; a result leaving as the
      // next one lands keeps it high
      if (out_xfer && (state_q != ST_DONE)) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        ST_IDLE: begin
          if (in_xfer && (in_data_i.op == OP_QUERY)) begin
            state_q <= ST_MUL;
          end
        end
        ST_MUL:  state_q <= ST_SUM;
        ST_SUM:  state_q <= ST_ADR;
        ST_ADR:  state_q <= ST_RD;
        ST_RD:   state_q <= ST_DONE;
        ST_DONE: begin
          if (out_free) begin
            out_valid_q         <= 1'b1;
            out_data_q.outside  <= map_outside;
            out_data_q.cell_out <= map_outside ? CELL_OUTSIDE : $signed(rd_q);
            state_q             <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

  // ---------------------------------------------------------------------------
  // Source store: one write port fed by loads, one registered read port fed by
  // the mapping unit. Writes only happen in IDLE, so a query's read never
  // overlaps a write.
  // ---------------------------------------------------------------------------
  logic [7:0]       grid_mem_q [Depth];
  logic             ld_we;
  logic [AddrW-1:0] ld_addr;

  assign ld_we   = in_xfer && (in_data_i.op == OP_LOAD) &&
                   (32'(in_data_i.col) < MAX_SRC_WIDTH) &&
                   (32'(in_data_i.row) < MAX_SRC_HEIGHT);
  assign ld_addr = AddrW'(32'(in_data_i.row) * MAX_SRC_WIDTH + 32'(in_data_i.col));

  always_ff @(posedge clk_i) begin
    if (ld_we) begin
      grid_mem_q[ld_addr] <= in_data_i.cell_in;
    end
    rd_q <= grid_mem_q[map_addr];
  end

endmodule

/* design/grn_map.sv */
// Inverse coordinate mapping: destination cell to rounded source cell and store address.
module grn_map
  import grn_pkg::*;
#(
  parameter int unsigned MAX_SRC_WIDTH  = MAX_SRC_WIDTH_DEF,
  parameter int unsigned MAX_SRC_HEIGHT = MAX_SRC_HEIGHT_DEF,
  parameter int unsigned TRIG_FRAC_BITS = TRIG_FRAC_BITS_DEF,
  localparam int unsigned AddrW = $clog2(MAX_SRC_WIDTH * MAX_SRC_HEIGHT)
) (
  input  logic             clk_i,
  input  cfg_t             cfg_i,
  input  logic [10:0]      col_i,
  input  logic [10:0]      row_i,
  output logic             outside_o,
  output logic [AddrW-1:0] addr_o
);

  localparam int unsigned ProdW = 29;
  localparam int unsigned SumW  = (((11 + TRIG_FRAC_BITS) > ProdW) ?
                                   (11 + TRIG_FRAC_BITS) : ProdW) + 3;
  localparam int unsigned IdxW  = SumW - TRIG_FRAC_BITS - 1;
  localparam int unsigned ColW  = $clog2(MAX_SRC_WIDTH);
  localparam int unsigned RowW  = $clog2(MAX_SRC_HEIGHT);
  localparam logic signed [IdxW-1:0] MaxW = IdxW'(MAX_SRC_WIDTH);
  localparam logic signed [IdxW-1:0] MaxH = IdxW'(MAX_SRC_HEIGHT);

  // stage 1: centered offsets in half cells, four products
  logic signed [12:0]      di, dj;
  logic signed [ProdW-1:0] p_dc_q, p_ds_q, p_is_q, p_jc_q;

  assign di = $signed({1'b0, col_i, 1'b0}) - $signed({1'b0, cfg_i.dst_width});
  assign dj = $signed({1'b0, row_i, 1'b0}) - $signed({1'b0, cfg_i.dst_height});

  always_ff @(posedge clk_i) begin
    p_dc_q <= di * cfg_i.cos_q;
    p_ds_q <= dj * cfg_i.sin_q;
    p_is_q <= di * cfg_i.sin_q;
    p_jc_q <= dj * cfg_i.cos_q;
  end

  // stage 2: center plus rounding half, then the rotated offsets
  logic signed [SumW-1:0] base_x, base_y, cx_d, cy_d, cx_q, cy_q;

  always_comb begin
    base_x = $signed(SumW'({1'b0, cfg_i.src_width} + 12'd1) << TRIG_FRAC_BITS);
    base_y = $signed(SumW'({1'b0, cfg_i.src_height} + 12'd1) << TRIG_FRAC_BITS);
    cx_d   = base_x + SumW'(p_dc_q) + SumW'(p_ds_q);
    cy_d   = base_y - SumW'(p_is_q) + SumW'(p_jc_q);
  end

  always_ff @(posedge clk_i) begin
    cx_q <= cx_d;
    cy_q <= cy_d;
  end

  // stage 3: floor by the half-cell scale, bounds check, address
  logic signed [SumW-1:0] cx_sh, cy_sh;
  logic signed [IdxW-1:0] ii, jj;
  logic                   outside_d;
  logic [AddrW-1:0]       addr_d;

  always_comb begin
    cx_sh     = cx_q >>> (TRIG_FRAC_BITS + 1);
    cy_sh     = cy_q >>> (TRIG_FRAC_BITS + 1);
    ii        = IdxW'(cx_sh);
    jj        = IdxW'(cy_sh);
    outside_d = ii[IdxW-1] || jj[IdxW-1] ||
                (ii >= IdxW'($signed({1'b0, cfg_i.src_width}))) ||
                (jj >= IdxW'($signed({1'b0, cfg_i.src_height}))) ||
                (ii >= MaxW) || (jj >= MaxH);
    addr_d    = AddrW'(32'(jj[RowW-1:0]) * MAX_SRC_WIDTH + 32'(ii[ColW-1:0]));
  end

  always_ff @(posedge clk_i) begin
    outside_o <= outside_d;
    addr_o    <= addr_d;
  end

endmodule

/* design/grn_checker.sv */
// Port-level checks for the grid rotation block, bound to the top level.
module grn_checker
  import grn_pkg::*;
(
  input logic                  clk_i,
  input logic                  rst_ni,
  input logic                  in_valid_i,
  input logic                  in_stall_o,
  input in_item_t              in_data_i,
  input logic                  out_valid_o,
  input logic                  out_stall_i,
  input out_item_t             out_data_o
);

  // a query keeps the input side closed while it is worked on
  a_query_blocks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o && (in_data_i.op == OP_QUERY)) |=> in_stall_o)
    else $error("input open right after a query transfer");

  // a load never blocks the next item
  a_load_open: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o && (in_data_i.op == OP_LOAD)) |=> !in_stall_o)
    else $error("input closed after a load transfer");

  // a new result only shows up at the end of a query
  a_result_from_query: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> ($past(in_stall_o) && !in_stall_o))
    else $error("result appeared without a query in progress");

  // outside positions report the unknown cell value
  a_outside_value: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_data_o.outside) |-> (out_data_o.cell_out == CELL_OUTSIDE))
    else $error("outside result with a cell value other than -1");

  // stalled result holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_stall_i) |=> (out_valid_o && $stable(out_data_o)))
    else $error("stalled result changed");

endmodule

bind grid_rotate_nearest_top grn_checker u_grn_checker (.*);

/* sim/tb_top.sv */
`timescale 1ns / 1ps
// Self-checking testbench for grid_rotate_nearest_top: directed edges, then random rotations.
module tb_top;
  import grn_pkg::*;

  localparam int unsigned STORE_W = MAX_SRC_WIDTH_DEF;
  localparam int unsigned STORE_H = MAX_SRC_HEIGHT_DEF;
  localparam int unsigned FRAC    = TRIG_FRAC_BITS_DEF;
  localparam longint      ONE_Q   = longint'(1) << FRAC;   // 1.0 in trig units

  // Indexes past the register file; writes there must change nothing.
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_6 = 3'd6;
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_7 = 3'd7;

  localparam int     TAIL_CYCLES = 12;          // margin for work still in flight
  localparam longint CYCLE_LIMIT = 2_000_000;
  localparam int     MAX_REPORTS = 40;
  localparam int     N_PHASES    = 12;
  localparam int     PHASE_ITEMS = 70;          // random picks per rotation phase
  localparam int     PREFILL_MAX = 200;         // grids up to this size are loaded up front

  // ---------------------------------------------------------------------------
  // Clock, reset, DUT
  // ---------------------------------------------------------------------------
  logic                  clk       = 1'b0;
  logic                  rst_n     = 1'b0;
  logic                  cfg_we    = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_wdata = '0;
  logic                  in_valid  = 1'b0;
  logic                  in_stall;
  in_item_t              in_data   = '0;
  logic                  out_valid;
  logic                  out_stall = 1'b0;
  out_item_t             out_data;

  always #5 clk = ~clk;

  grid_rotate_nearest_top dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .cfg_we_i    (cfg_we),
    .cfg_index_i (cfg_index),
    .cfg_wdata_i (cfg_wdata),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .in_data_i   (in_data),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .out_data_o  (out_data)
  );

  // ---------------------------------------------------------------------------
  // Predictor state: shadow registers, source store, results still owed
  // ---------------------------------------------------------------------------
  logic [10:0]        src_w_q = 11'd1024;
  logic [10:0]        src_h_q = 11'd1024;
  logic [11:0]        dst_w_q = 12'd1024;
  logic [11:0]        dst_h_q = 12'd1024;
  logic signed [15:0] cos_q   = 16'sd16384;
  logic signed [15:0] sin_q   = 16'sd0;

  // Sparse copy of the store; an entry exists only once a load wrote it.
  logic signed [7:0]  grid_mem [int unsigned];
  out_item_t          pending_cells [$];

  typedef struct {
    logic off_grid;
    int   ii;
    int   jj;
  } src_pos_t;

  bit     calm = 1'b0;           // no gaps and no new stalls while set
  int     err_count = 0;
  int     n_loads = 0;
  int     n_dropped = 0;
  int     n_queries = 0;
  int     n_checked = 0;
  int     n_outside = 0;
  int     stall_left = 0;
  longint cycle_count = 0;

  function automatic int unsigned cell_addr(int ii, int jj);
    return jj * STORE_W + ii;
  endfunction

  // Inverse mapping in half-cell units; floor(x + 0.5) is add ONE_Q (half a
  // cell), then an arithmetic shift by FRAC + 1.
  function automatic src_pos_t map_to_source(logic [10:0] col, logic [10:0] row);
    longint   di, dj, cx, cy, ii, jj;
    src_pos_t p;
    di = 2 * longint'(col) - longint'(dst_w_q);
    dj = 2 * longint'(row) - longint'(dst_h_q);
    cx = longint'(src_w_q) * ONE_Q + di * longint'(cos_q) + dj * longint'(sin_q) + ONE_Q;
    cy = longint'(src_h_q) * ONE_Q - di * longint'(sin_q) + dj * longint'(cos_q) + ONE_Q;
    ii = cx >>> (FRAC + 1);
    jj = cy >>> (FRAC + 1);
    // outside the configured grid, or past the physical store
    p.off_grid = ii < 0 || jj < 0 ||
                 ii >= longint'(src_w_q) || jj >= longint'(src_h_q) ||
                 ii >= longint'(STORE_W) || jj >= longint'(STORE_H);
    p.ii = int'(ii);
    p.jj = int'(jj);
    return p;
  endfunction

  // Called once per accepted input transfer, in transfer order.
  function automatic void predict_item(in_item_t it);
    src_pos_t    p;
    out_item_t   r;
    int unsigned a;
    if (it.op == OP_LOAD) begin
      n_loads++;
      if (it.col < STORE_W && it.row < STORE_H) grid_mem[cell_addr(it.col, it.row)] = it.cell_in;
      else n_dropped++;
    end else begin
      n_queries++;
      p = map_to_source(it.col, it.row);
      if (p.off_grid) begin
        r.cell_out = CELL_OUTSIDE;
        r.outside  = 1'b1;
      end else begin
        a = cell_addr(p.ii, p.jj);
        r.cell_out = grid_mem.exists(a) ? grid_mem[a] : 8'sd0;
        r.outside  = 1'b0;
      end
      pending_cells.push_back(r);
    end
  endfunction

  // ---------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------
  function automatic int pick_gap();
    int r;
    if (calm) return 0;
    r = $urandom_range(99);
    if (r < 55) return 0;
    if (r < 88) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // Mostly legal occupancy (-1..100), now and then any byte.
  function automatic logic signed [7:0] pick_cell();
    if ($urandom_range(9) == 0) return 8'($urandom);
    return 8'(int'($urandom_range(101)) - 1);
  endfunction

  function automatic in_item_t make_item(logic op, logic [10:0] col, logic [10:0] row,
                                         logic signed [7:0] cell_val);
    in_item_t it;
    it.op      = op;
    it.col     = col;
    it.row     = row;
    it.cell_in = cell_val;
    return it;
  endfunction

  // Size of the rotated bounding box along one axis.
  function automatic logic [11:0] span_of(int a, int b, int ca, int sb);
    int v;
    v = (a * (ca < 0 ? -ca : ca) + b * (sb < 0 ? -sb : sb) + 16383) / 16384;
    if (v < 1) v = 1;
    if (v > 4095) v = 4095;
    return 12'(v);
  endfunction

  task automatic pick_angle(output logic signed [15:0] c, output logic signed [15:0] s);
    real a;
    a = $urandom_range(3599) * 3.141592653589793 / 1800.0;
    c = 16'(int'($cos(a) * 16384.0));
    s = 16'(int'($sin(a) * 16384.0));
  endtask

  // One input transfer. Valid stays high into the next call when there is no
  // gap, so it is never lowered and raised in the same step.
  task automatic send_item(in_item_t it);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= it;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    predict_item(it);
  endtask

  // A query whose source cell is inside the grid gets that cell loaded first,
  // so no never-written entry is ever read.
  task automatic send_query(logic [10:0] col, logic [10:0] row);
    src_pos_t p;
    p = map_to_source(col, row);
    if (!p.off_grid && !grid_mem.exists(cell_addr(p.ii, p.jj)))
      send_item(make_item(OP_LOAD, 11'(p.ii), 11'(p.jj), pick_cell()));
    send_item(make_item(OP_QUERY, col, row, 8'($urandom)));
  endtask

  // Sender holds off until every owed result is back.
  task automatic wait_results();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_cells.size() != 0) @(posedge clk);
  endtask

  // Idle the block fully: results back, then the tail of any load in flight.
  task automatic settle();
    wait_results();
    repeat (TAIL_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      CFG_SRC_WIDTH:  src_w_q = val[10:0];
      CFG_SRC_HEIGHT: src_h_q = val[10:0];
      CFG_DST_WIDTH:  dst_w_q = val[11:0];
      CFG_DST_HEIGHT: dst_h_q = val[11:0];
      CFG_COS_Q:      cos_q   = val;
      CFG_SIN_Q:      sin_q   = val;
      default: ;
    endcase
    @(posedge clk);
  endtask

  task automatic set_config(logic [10:0] sw, logic [10:0] sh, logic [11:0] dw,
                            logic [11:0] dh, logic signed [15:0] c, logic signed [15:0] s);
    settle();
    write_reg(CFG_SRC_WIDTH,  16'(sw));
    write_reg(CFG_SRC_HEIGHT, 16'(sh));
    write_reg(CFG_DST_WIDTH,  16'(dw));
    write_reg(CFG_DST_HEIGHT, 16'(dh));
    write_reg(CFG_COS_Q,      c);
    write_reg(CFG_SIN_Q,      s);
  endtask

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Reset defaults give an identity map on a 1024 x 1024 grid.
  task automatic test_identity_edges();
    send_item(make_item(OP_LOAD, 11'd0,    11'd0,    -8'sd1));
    send_item(make_item(OP_LOAD, 11'd1023, 11'd1023, 8'sd100));
    send_item(make_item(OP_LOAD, 11'd3,    11'd2,    8'sd10));
    send_item(make_item(OP_LOAD, 11'd5,    11'd5,    8'h80));
    // loads past the store edge are dropped; a wrapped address would hit
    // (3,2) or (1023,1023)
    send_item(make_item(OP_LOAD, 11'd1027, 11'd2,    8'sd77));
    send_item(make_item(OP_LOAD, 11'd3,    11'd1026, 8'sd55));
    send_item(make_item(OP_LOAD, 11'd2047, 11'd2047, 8'sd127));
    send_query(11'd0,    11'd0);       // stored -1, not flagged outside
    send_query(11'd1023, 11'd1023);
    send_query(11'd3,    11'd2);
    send_query(11'd5,    11'd5);
    send_query(11'd1024, 11'd0);
    send_query(11'd0,    11'd1024);
    send_query(11'd2047, 11'd2047);
  endtask

  task automatic test_register_edges();
    settle();
    write_reg(CFG_SPARE_6, 16'hFFFF);
    write_reg(CFG_SPARE_7, 16'h8000);
    send_query(11'd3, 11'd2);          // map must still be identity

    // zero source width: every position is outside
    settle();
    write_reg(CFG_SRC_WIDTH, 16'd0);
    send_query(11'd0, 11'd0);
    send_query(11'd512, 11'd512);

    // source size past the store: (1,0) lands on column 1024, in the grid
    // but past the store, so outside
    set_config(11'd2047, 11'd2047, 12'd1, 12'd1, 16'sd16384, 16'sd0);
    send_query(11'd0, 11'd0);
    send_query(11'd1, 11'd0);
    set_config(11'd2047, 11'd2047, 12'd0, 12'd0, 16'sd16384, 16'sd0);
    send_query(11'd0, 11'd0);

    // widest destination
    set_config(11'd1024, 11'd1024, 12'd4095, 12'd4095, 16'sd16384, 16'sd0);
    send_query(11'd2047, 11'd2047);
    send_query(11'd0, 11'd0);

    // most negative cosine, most positive sine
    set_config(11'd1024, 11'd1024, 12'd1024, 12'd1024, 16'sh8000, 16'sh7FFF);
    send_query(11'd512, 11'd512);
    send_query(11'd0, 11'd2047);
  endtask

  // Random phases: set a rotation, fill small grids, then mostly queries
  // inside the destination window with some loads and noise.
  task automatic run_phase(logic [10:0] sw, logic [10:0] sh, logic [11:0] dw,
                           logic [11:0] dh, logic signed [15:0] c,
                           logic signed [15:0] s, int n, bit hold_mid);
    int lw, lh, qw, qh, r;
    set_config(sw, sh, dw, dh, c, s);
    lw = (sw == 0) ? 1 : ((sw > STORE_W) ? STORE_W : int'(sw));
    lh = (sh == 0) ? 1 : ((sh > STORE_H) ? STORE_H : int'(sh));
    qw = (int'(dw) + 1 > 2047) ? 2047 : int'(dw) + 1;
    qh = (int'(dh) + 1 > 2047) ? 2047 : int'(dh) + 1;
    if (lw * lh <= PREFILL_MAX) begin
      for (int y = 0; y < lh; y++)
        for (int x = 0; x < lw; x++)
          send_item(make_item(OP_LOAD, 11'(x), 11'(y), pick_cell()));
    end
    for (int k = 0; k < n; k++) begin
      if (k % 40 == 0) calm = ($urandom_range(3) == 0);
      if (hold_mid && k == n / 2) wait_results();
      r = $urandom_range(99);
      if (r < 65)
        send_query(11'($urandom_range(qw)), 11'($urandom_range(qh)));
      else if (r < 85)
        send_item(make_item(OP_LOAD, 11'($urandom_range(lw - 1)),
                            11'($urandom_range(lh - 1)), pick_cell()));
      else if (r < 93)
        send_item(make_item(OP_LOAD, 11'($urandom), 11'($urandom), 8'($urandom)));
      else
        send_query(11'($urandom), 11'($urandom));
    end
    calm = 1'b0;
  endtask

  task automatic test_random_rotations();
    logic signed [15:0] c, s;
    int                 sw, sh;
    bit                 hold;
    for (int p = 0; p < N_PHASES; p++) begin
      hold = (p == 0 || p == 10 || $urandom_range(3) == 0);
      pick_angle(c, s);
      sw = $urandom_range(1, 24);
      sh = $urandom_range(1, 24);
      case (p)
        0: run_phase(11'd1024, 11'd1024, 12'd1024, 12'd1024, 16'sd16384, 16'sd0,
                     PHASE_ITEMS, hold);
        1: run_phase(11'd16, 11'd12, span_of(16, 12, c, s), span_of(16, 12, s, c),
                     c, s, PHASE_ITEMS, hold);
        // quarter turns with exact trig values
        2: run_phase(11'd20, 11'd9, 12'd9, 12'd20, 16'sd0, 16'sd16384, PHASE_ITEMS, hold);
        3: run_phase(11'd13, 11'd17, 12'd13, 12'd17, -16'sd16384, 16'sd0, PHASE_ITEMS, hold);
        4: run_phase(11'd7, 11'd24, 12'd24, 12'd7, 16'sd0, -16'sd16384, PHASE_ITEMS, hold);
        5: run_phase(11'd1, 11'd1, span_of(1, 1, c, s), span_of(1, 1, s, c), c, s,
                     PHASE_ITEMS, hold);
        // full store, filled on demand
        6: run_phase(11'd1024, 11'd1024, span_of(1024, 1024, c, s),
                     span_of(1024, 1024, s, c), c, s, PHASE_ITEMS, hold);
        7: run_phase(11'd2047, 11'd2047, 12'd4095, 12'd4095, c, s, PHASE_ITEMS, hold);
        8: begin
          if ($urandom_range(1) == 0) run_phase(11'd30, 11'd30, 12'd40, 12'd40,
                                                16'sh7FFF, 16'sh8000, PHASE_ITEMS, hold);
          else run_phase(11'd30, 11'd30, 12'd40, 12'd40, 16'sh8000, 16'sh7FFF,
                         PHASE_ITEMS, hold);
        end
        9: run_phase(11'(sw), 11'(sh), 12'd0, 12'($urandom_range(1, 64)), c, s,
                     PHASE_ITEMS, hold);
        10: run_phase(11'(sw), 11'(sh), 12'($urandom_range(1, 64)),
                      12'($urandom_range(1, 64)), c, s, PHASE_ITEMS, hold);
        // near-zero angle: should come out as a plain copy
        default: begin
          s = 16'(int'($urandom_range(1, 60)));
          if ($urandom_range(1) == 0) s = -s;
          run_phase(11'(sw), 11'(sh), 12'(sw), 12'(sh), 16'sd16384, s, PHASE_ITEMS, hold);
        end
      endcase
    end
  endtask

  // ---------------------------------------------------------------------------
  // Result side: random receiver stalls and the per-transfer check
  // ---------------------------------------------------------------------------
  function automatic void report(string what, logic signed [8:0] want, logic signed [8:0] got);
    err_count++;
    if (err_count <= MAX_REPORTS)
      $display("%0t ns: %s mismatch, expected %0d, got %0d", $time, what, want, got);
    else if (err_count == MAX_REPORTS + 1)
      $display("%0t ns: further mismatches counted but not shown", $time);
  endfunction

  always @(posedge clk) begin : result_side
    out_item_t want;
    int        r;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_cells.size() == 0) begin
        err_count++;
        $display("%0t ns: result transfer with none expected, expected nothing, got %0d/%0b",
                 $time, out_data.cell_out, out_data.outside);
      end else begin
        want = pending_cells.pop_front();
        n_checked++;
        if (want.outside) n_outside++;
        if (out_data.cell_out !== want.cell_out) report("cell_out", want.cell_out,
                                                        out_data.cell_out);
        if (out_data.outside !== want.outside) report("outside", want.outside,
                                                      out_data.outside);
      end
    end
    // stall pattern: runs of ready, short stalls, a few long ones
    if (stall_left > 0) stall_left--;
    else begin
      r = $urandom_range(99);
      if (calm || r < 50) begin
        out_stall  <= 1'b0;
        stall_left = $urandom_range(0, 6);
      end else if (r < 93) begin
        out_stall  <= 1'b1;
        stall_left = $urandom_range(0, 3);
      end else begin
        out_stall  <= 1'b1;
        stall_left = $urandom_range(10, 40);
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles, %0d results outstanding",
               cycle_count, pending_cells.size());
      $display("CHECK FAILED");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Sequence
  // ---------------------------------------------------------------------------
  initial begin
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_identity_edges();
    test_register_edges();
    test_random_rotations();
    settle();
    $display("Covered: %0d loads (%0d past the store), %0d queries, %0d results checked",
             n_loads, n_dropped, n_queries, n_checked);
    $display("         %0d outside hits over %0d rotation phases; %0d mismatches",
             n_outside, N_PHASES, err_count);
    if (err_count == 0) $display("CHECK OK");
    else $display("CHECK FAILED");
    $finish;
  end

endmodule

/* sim.f */
design/grn_pkg.sv
design/grn_map.sv
design/grid_rotate_nearest_top.sv
design/grn_checker.sv
sim/tb_top.sv
